### src/rlee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlee_pkg
// Shared types, constants and run encoding helpers for the RLE escape encoder.
// ----------------------------------------------------------------------------
package rlee_pkg;

    localparam logic [7:0] RUN_MAX       = 8'd254;
    localparam logic [7:0] ESC_BYTE      = 8'hFF;
    localparam logic [7:0] MIN_PLAIN_RUN = 8'd3;
    localparam logic [7:0] MIN_ESC_RUN   = 8'd2;

    // command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one closed run
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] length;
    } t_run;

    // work for the back end from one input item: one or two runs to emit
    typedef struct packed {
        t_run a;
        logic has_b;
        t_run b;
        logic last;
    } t_cmd;

    // number of encoded bytes for a run of value v and length n (n >= 1)
    function automatic logic [1:0] run_nbytes(logic [7:0] v, logic [7:0] n);
        logic [1:0] res;
        if (v == ESC_BYTE) begin
            res = (n >= MIN_ESC_RUN) ? 2'd3 : 2'd2;
        end else begin
            res = (n >= MIN_PLAIN_RUN) ? 2'd3 : n[1:0];
        end
        return res;
    endfunction

    // encoded byte at position idx of a run of value v and length n
    function automatic logic [7:0] run_byte(logic [7:0] v, logic [7:0] n, logic [1:0] idx);
        logic [7:0] res;
        res = v;
        if ((v == ESC_BYTE && n >= MIN_ESC_RUN) || (v != ESC_BYTE && n >= MIN_PLAIN_RUN)) begin
            case (idx)
                2'd0:    res = ESC_BYTE;
                2'd1:    res = n;
                default: res = v;
            endcase
        end
        return res;
    endfunction

endpackage

### src/rlee_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlee_front
// Accepts input bytes, tracks the open run and queues the runs to be emitted.
// ----------------------------------------------------------------------------
module rlee_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_in_byte,
    input  logic           i_in_last,
    output logic           o_stall,
    input  logic           i_q_full,
    output logic           o_push,
    output rlee_pkg::t_cmd o_cmd
);

    logic [7:0] r_run_value,  n_run_value;
    logic [7:0] r_run_length, n_run_length;
    logic       accept;
    logic       extend;
    logic       close_run;
    rlee_pkg::t_run run_closed;
    rlee_pkg::t_run run_open;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    // classify the byte against the open run
    always_comb begin
        extend = (r_run_length != 8'd0) && (i_in_byte == r_run_value)
                 && (r_run_length < rlee_pkg::RUN_MAX);
        close_run = !extend && (r_run_length != 8'd0);
        run_closed.value  = r_run_value;
        run_closed.length = r_run_length;
        if (extend) begin
            run_open.value  = r_run_value;
            run_open.length = r_run_length + 8'd1;
        end else begin
            run_open.value  = i_in_byte;
            run_open.length = 8'd1;
        end
        if (i_in_last) begin
            n_run_value  = 8'd0;
            n_run_length = 8'd0;
        end else begin
            n_run_value  = run_open.value;
            n_run_length = run_open.length;
        end
    end

    // build the queue command: closed run first, then the flushed run
    always_comb begin
        o_push       = accept && (close_run || i_in_last);
        o_cmd.last   = i_in_last;
        o_cmd.has_b  = close_run && i_in_last;
        o_cmd.a      = close_run ? run_closed : run_open;
        o_cmd.b      = run_open;
    end

    // advance run state on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_value  <= 8'd0;
            r_run_length <= 8'd0;
        end else if (accept) begin
            r_run_value  <= n_run_value;
            r_run_length <= n_run_length;
        end
    end

endmodule

### src/rlee_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlee_queue
// Small register queue of run commands between front and back end.
// ----------------------------------------------------------------------------
module rlee_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rlee_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_not_empty,
    output rlee_pkg::t_cmd o_head
);

    localparam int CNT_W = rlee_pkg::QPTR_W + 1;

    rlee_pkg::t_cmd              r_mem [rlee_pkg::QUEUE_DEPTH];
    logic [rlee_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [rlee_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0]            r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full      = (r_count == CNT_W'(rlee_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    // store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/rlee_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlee_back
// Walks the queued runs and emits one encoded byte per transfer.
// ----------------------------------------------------------------------------
module rlee_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_not_empty,
    input  rlee_pkg::t_cmd i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_item_last,
    output logic           o_stream_last
);

    logic       r_sel,  n_sel;
    logic [1:0] r_idx,  n_idx;
    logic       r_o_valid;
    logic [7:0] r_out_byte;
    logic       r_item_last;
    logic       r_stream_last;
    logic       out_free;
    logic       adv;
    logic       run_end;
    logic       entry_end;
    logic [1:0] nbytes;
    rlee_pkg::t_run cur;

    assign o_valid       = r_o_valid;
    assign o_out_byte    = r_out_byte;
    assign o_item_last   = r_item_last;
    assign o_stream_last = r_stream_last;

    // pick the current run and byte position
    always_comb begin
        cur       = r_sel ? i_head.b : i_head.a;
        nbytes    = rlee_pkg::run_nbytes(cur.value, cur.length);
        out_free  = !r_o_valid || !i_stall;
        adv       = i_q_not_empty && out_free;
        run_end   = (r_idx == (nbytes - 2'd1));
        entry_end = run_end && (r_sel || !i_head.has_b);
        o_pop     = adv && entry_end;
        n_sel     = r_sel;
        n_idx     = r_idx;
        if (adv) begin
            if (run_end) begin
                n_idx = 2'd0;
                n_sel = !entry_end;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    // hold sequencer position and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel     <= 1'b0;
            r_idx     <= 2'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_sel <= n_sel;
            r_idx <= n_idx;
            if (out_free) begin
                r_o_valid <= i_q_not_empty;
            end
        end
    end

    // load the output payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte    <= rlee_pkg::run_byte(cur.value, cur.length, r_idx);
            r_item_last   <= entry_end;
            r_stream_last <= entry_end && i_head.last;
        end
    end

endmodule

### src/rle_escape_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_escape_encoder_core
// Streaming byte run-length encoder with 0xFF as escape byte.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle while the four-entry run queue has room; a
// byte that only opens or extends a run uses no queue entry. Encoded bytes
// leave one per cycle, while the output is not stalled and the queue holds a
// run, through a registered output, so each closed run yields one to three
// encoded bytes (two runs, up to six bytes, for a final byte that also closes
// a run). Sustained rate is therefore set by the single output byte port,
// most of all when every byte ends a lone escape run. The output port may
// stall freely; the input side stalls only when the queue is full.
module rle_escape_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_item_last,
    output logic       o_stream_last
);

    rlee_pkg::t_cmd push_cmd;
    rlee_pkg::t_cmd head_cmd;
    logic           push;
    logic           q_full;
    logic           pop;
    logic           q_not_empty;

    rlee_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_stall   (o_stall),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    rlee_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (push_cmd),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_head      (head_cmd)
    );

    rlee_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_head        (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_item_last   (o_item_last),
        .o_stream_last (o_stream_last)
    );

endmodule
